@@ design/tsce_pkg.sv @@
// Shared types and constants for the tty screen character engine.
// No dependencies; used by tsce_screen_mem and the top level.
`default_nettype none

package tsce_pkg;

    localparam int SCREEN_COLS = 80;
    localparam int SCREEN_ROWS = 25;
    localparam int CELLS       = SCREEN_COLS * SCREEN_ROWS;
    localparam int ADDR_W      = $clog2(CELLS);

    localparam int ROW_W  = 5;
    localparam int COL_W  = 7;
    localparam int CHAR_W = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 1;

    localparam logic [CHAR_W-1:0] BLANK  = 8'h20;
    localparam logic [CHAR_W-1:0] CH_BEL = 8'h07;
    localparam logic [CHAR_W-1:0] CH_BS  = 8'h08;
    localparam logic [CHAR_W-1:0] CH_LF  = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_CR  = 8'h0D;

    localparam logic REQ_BYTE = 1'b0;
    localparam logic REQ_READ = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_NEWLINE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LF_CR    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_AUTOWRAP = 2'd2;

    typedef struct packed {
        logic              req_type;
        logic [CHAR_W-1:0] rx_byte;
        logic [ROW_W-1:0]  read_row;
        logic [COL_W-1:0]  read_col;
    } t_in_item;

    typedef struct packed {
        logic [CHAR_W-1:0] read_char;
        logic              bell;
        logic              scrolled;
        logic [ROW_W-1:0]  cursor_row;
        logic [COL_W-1:0]  cursor_col;
    } t_out_item;

    // Cursor, top-row pointer and the number of rows scrolled by one byte
    typedef struct packed {
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] top;
        logic [1:0]       nscr;
    } t_cursor;

endpackage

`default_nettype wire

@@ design/tsce_screen_mem.sv @@
// Screen cell store: one write port, one read port with registered data.
// Depends on tsce_pkg for depth and widths.
`default_nettype none

module tsce_screen_mem (
    input  wire logic                       i_clk,
    input  wire logic                       i_we,
    input  wire logic [tsce_pkg::ADDR_W-1:0] i_waddr,
    input  wire logic [tsce_pkg::CHAR_W-1:0] i_wdata,
    input  wire logic [tsce_pkg::ADDR_W-1:0] i_raddr,
    output logic      [tsce_pkg::CHAR_W-1:0] o_rdata
);

    logic [tsce_pkg::CHAR_W-1:0] r_mem [tsce_pkg::CELLS];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

@@ design/tty_screen_character_engine_unit.sv @@
// Top level: byte interpreter, cursor and scroll sequencer around the screen store.
// A byte without scroll raises o_done in the cycle after it is accepted; a read goes via
// S_READ; a scrolling byte blanks SCREEN_COLS cells per scrolled row (80 or 160), busy held.
// Throughput set by the single write port of the cell store during row clears.
// Reset: cursor, top row and registers cleared (autowrap set), then a pass over all
// CELLS (2000) cells fills the store with spaces while busy is high. The receiver cannot stall.
`default_nettype none

module tty_screen_character_engine_unit (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            start,
    output logic                                 busy,
    input  wire tsce_pkg::t_in_item              i_item,
    output logic                                 o_done,
    output tsce_pkg::t_out_item                  o_result,
    input  wire logic                            i_cfg_we,
    input  wire logic [tsce_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [tsce_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    localparam int ADDR_W = tsce_pkg::ADDR_W;
    localparam int ROW_W  = tsce_pkg::ROW_W;
    localparam int COL_W  = tsce_pkg::COL_W;
    localparam logic [ROW_W-1:0]  LAST_ROW  = ROW_W'(tsce_pkg::SCREEN_ROWS - 1);
    localparam logic [COL_W-1:0]  LAST_COL  = COL_W'(tsce_pkg::SCREEN_COLS - 1);
    localparam logic [ADDR_W-1:0] LAST_CELL = ADDR_W'(tsce_pkg::CELLS - 1);
    localparam logic [ADDR_W-1:0] ONE_ROW   = ADDR_W'(tsce_pkg::SCREEN_COLS - 1);
    localparam logic [ADDR_W-1:0] TWO_ROWS  = ADDR_W'(2 * tsce_pkg::SCREEN_COLS - 1);

    typedef enum logic [3:0] {
        S_INIT  = 4'b0001,
        S_IDLE  = 4'b0010,
        S_READ  = 4'b0100,
        S_CLEAR = 4'b1000
    } t_state;

    t_state              r_state;
    logic [ROW_W-1:0]    r_row;
    logic [COL_W-1:0]    r_col;
    logic [ROW_W-1:0]    r_top;
    logic                r_newline;
    logic                r_lf_cr;
    logic                r_autowrap;
    logic [ADDR_W-1:0]   r_clr_addr;
    logic [ADDR_W-1:0]   r_clr_cnt;
    logic                r_rd_ok;
    logic                r_done;
    tsce_pkg::t_out_item r_result;

    tsce_pkg::t_cursor   n_cur;
    logic                n_bell;
    logic                n_print;
    logic                w_accept;
    logic                w_rd_ok;
    logic [ADDR_W-1:0]   w_rd_addr;
    logic [ADDR_W-1:0]   w_cur_addr;
    logic [ADDR_W-1:0]   w_top_addr;
    logic                w_clearing;
    logic                w_we;
    logic [ADDR_W-1:0]   w_waddr;
    logic [tsce_pkg::CHAR_W-1:0] w_wdata;
    logic [tsce_pkg::CHAR_W-1:0] w_rdata;

    function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] vis,
                                                   input logic [COL_W-1:0] col,
                                                   input logic [ROW_W-1:0] top);
        logic [ROW_W:0] sum;
        logic [ROW_W:0] phys;
        begin
            sum  = {1'b0, top} + {1'b0, vis};
            phys = (sum >= (ROW_W+1)'(tsce_pkg::SCREEN_ROWS))
                 ? sum - (ROW_W+1)'(tsce_pkg::SCREEN_ROWS) : sum;
            return ADDR_W'(phys) * ADDR_W'(tsce_pkg::SCREEN_COLS) + ADDR_W'(col);
        end
    endfunction

    function automatic tsce_pkg::t_cursor line_feed(input tsce_pkg::t_cursor c,
                                                   input logic lf_cr);
        tsce_pkg::t_cursor r;
        begin
            r = c;
            if (c.row >= LAST_ROW) begin
                r.row  = LAST_ROW;
                r.top  = (c.top == LAST_ROW) ? '0 : c.top + 1'b1;
                r.nscr = c.nscr + 1'b1;
            end else begin
                r.row = c.row + 1'b1;
            end
            if (lf_cr) begin
                r.col = '0;
            end
            return r;
        end
    endfunction

    always_comb begin
        n_cur   = '{row: r_row, col: r_col, top: r_top, nscr: 2'd0};
        n_bell  = 1'b0;
        n_print = 1'b0;
        unique case (i_item.rx_byte)
            tsce_pkg::CH_BEL: n_bell = 1'b1;
            tsce_pkg::CH_BS: begin
                if (r_col != '0) begin
                    n_cur.col = r_col - 1'b1;
                end
            end
            tsce_pkg::CH_CR: begin
                n_cur.col = '0;
                if (r_newline) begin
                    n_cur = line_feed(n_cur, r_lf_cr);
                end
            end
            tsce_pkg::CH_LF: n_cur = line_feed(n_cur, r_lf_cr);
            default: begin
                n_print = 1'b1;
                if (r_col < LAST_COL) begin
                    n_cur.col = r_col + 1'b1;
                end else if (r_autowrap) begin
                    // wrap acts as CR then LF received in turn
                    n_cur.col = '0;
                    if (r_newline) begin
                        n_cur = line_feed(n_cur, r_lf_cr);
                    end
                    n_cur = line_feed(n_cur, r_lf_cr);
                end
            end
        endcase
    end

    assign w_accept   = start && (r_state == S_IDLE);
    assign busy       = (r_state != S_IDLE);
    assign w_rd_ok    = (i_item.read_row <= LAST_ROW) && (i_item.read_col <= LAST_COL);
    assign w_rd_addr  = w_rd_ok ? cell_addr(i_item.read_row, i_item.read_col, r_top) : '0;
    assign w_cur_addr = cell_addr(r_row, r_col, r_top);
    assign w_top_addr = cell_addr('0, '0, r_top);
    assign w_clearing = (r_state == S_INIT) || (r_state == S_CLEAR);
    assign w_we       = w_clearing
                     || (w_accept && (i_item.req_type == tsce_pkg::REQ_BYTE) && n_print);
    assign w_waddr    = w_clearing ? r_clr_addr : w_cur_addr;
    assign w_wdata    = w_clearing ? tsce_pkg::BLANK : i_item.rx_byte;

    tsce_screen_mem u_mem (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_rd_addr),
        .o_rdata (w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_INIT;
            r_row      <= '0;
            r_col      <= '0;
            r_top      <= '0;
            r_newline  <= 1'b0;
            r_lf_cr    <= 1'b0;
            r_autowrap <= 1'b1;
            r_clr_addr <= '0;
            r_clr_cnt  <= LAST_CELL;
            r_rd_ok    <= 1'b0;
            r_done     <= 1'b0;
            r_result   <= '0;
        end else begin
            r_done <= 1'b0;

            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    tsce_pkg::CFG_NEWLINE:  r_newline  <= i_cfg_data[0];
                    tsce_pkg::CFG_LF_CR:    r_lf_cr    <= i_cfg_data[0];
                    tsce_pkg::CFG_AUTOWRAP: r_autowrap <= i_cfg_data[0];
                    default: ;
                endcase
            end

            unique case (r_state)
                S_INIT, S_CLEAR: begin
                    r_clr_addr <= (r_clr_addr == LAST_CELL) ? '0 : r_clr_addr + 1'b1;
                    r_clr_cnt  <= r_clr_cnt - 1'b1;
                    if (r_clr_cnt == '0) begin
                        r_state <= S_IDLE;
                        if (r_state == S_CLEAR) begin
                            r_done   <= 1'b1;
                            r_result <= '{read_char: '0, bell: 1'b0, scrolled: 1'b1,
                                          cursor_row: r_row, cursor_col: r_col};
                        end
                    end
                end
                S_READ: begin
                    r_state  <= S_IDLE;
                    r_done   <= 1'b1;
                    r_result <= '{read_char: r_rd_ok ? w_rdata : '0, bell: 1'b0,
                                  scrolled: 1'b0, cursor_row: r_row, cursor_col: r_col};
                end
                S_IDLE: begin
                    if (w_accept) begin
                        if (i_item.req_type == tsce_pkg::REQ_READ) begin
                            r_state <= S_READ;
                            r_rd_ok <= w_rd_ok;
                        end else begin
                            r_row <= n_cur.row;
                            r_col <= n_cur.col;
                            r_top <= n_cur.top;
                            if (n_cur.nscr != 2'd0) begin
                                // blank the old top row, and the next if two scrolled
                                r_state    <= S_CLEAR;
                                r_clr_addr <= w_top_addr;
                                r_clr_cnt  <= (n_cur.nscr == 2'd1) ? ONE_ROW : TWO_ROWS;
                            end else begin
                                r_done   <= 1'b1;
                                r_result <= '{read_char: '0, bell: n_bell, scrolled: 1'b0,
                                              cursor_row: n_cur.row, cursor_col: n_cur.col};
                            end
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_done   = r_done;
    assign o_result = r_result;

endmodule

`default_nettype wire
